/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros used by the checker module
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only outside reset
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/mibc_pkg.sv */
// ---------------------------------------------------------------------------
// mibc_pkg
// Types and constants of the main I/O, interrupt and beep controller.
// ---------------------------------------------------------------------------
package mibc_pkg;

  // Item opcodes
  typedef enum logic [2:0] {
    OP_READ      = 3'd0,
    OP_WRITE     = 3'd1,
    OP_TIMER     = 3'd2,
    OP_BEEP_END  = 3'd3,
    OP_DISK_IRQ  = 3'd4,
    OP_PRN_IRQ   = 3'd5,
    OP_KEY_PRESS = 3'd6,
    OP_DISK_ACK  = 3'd7
  } opcode_t;

  // Register offsets within the I/O page
  localparam logic [3:0] OFF_KEY_HI = 4'h0;
  localparam logic [3:0] OFF_KEY_LO = 4'h1;
  localparam logic [3:0] OFF_IRQ_EN = 4'h2;
  localparam logic [3:0] OFF_CAUSE  = 4'h3;
  localparam logic [3:0] OFF_ROM_SW = 4'hf;

  // Configuration register indexes
  localparam logic [1:0] CFG_FM8_MODE  = 2'd0;
  localparam logic [1:0] CFG_LOW_SPEED = 2'd1;
  localparam logic [1:0] CFG_BANK_EN   = 2'd2;

  // Cause flag bit positions
  localparam int unsigned C_KEY   = 0;
  localparam int unsigned C_PRN   = 1;
  localparam int unsigned C_TIMER = 2;
  localparam int unsigned C_DISK  = 3;

  // Enable bit positions
  localparam int unsigned E_KEY   = 0;
  localparam int unsigned E_PRN   = 1;
  localparam int unsigned E_TIMER = 2;
  localparam int unsigned E_DISK  = 3;

  // Read data constants
  localparam logic [7:0] RD_ALL_ONES    = 8'hff;
  localparam logic [7:0] KEY_HI_CLEAR   = 8'h7f;
  localparam logic [7:0] LOW_SPEED_MASK = 8'hfe;

endpackage

/* rtl/main_io_interrupt_beep_controller_top.sv */
// An accepted item passes the input register and then the output register
// to the result ports. Throughput: one item per cycle while out_ready holds;
// each register holds one item, so one more is taken while a result waits.
// Reset: synchronous active-low rst_n empties both stages, clears causes,
// enables, beep and speaker, and sets ROM mapped and BASIC boot.
// ---------------------------------------------------------------------------
// main_io_interrupt_beep_controller_top
// Keyboard, interrupt enable/cause, beeper and ROM switch registers of the
// main CPU I/O page, plus event handling, one result item per input item.
// ---------------------------------------------------------------------------
module main_io_interrupt_beep_controller_top (
  input  logic       clk,
  input  logic       rst_n,
  // input items
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_opcode,
  input  logic [3:0] in_reg_offset,
  input  logic [7:0] in_write_data,
  input  logic [8:0] in_key_code,
  input  logic       in_other_irq_pending,
  // result items
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_handled,
  output logic [3:0] out_pending_causes,
  output logic       out_beep_on,
  output logic       out_speaker_on,
  output logic       out_basic_rom_on,
  output logic       out_basic_boot,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic       cfg_data
);
  import mibc_pkg::*;

  // configuration
  logic fm8_mode_r, low_speed_r, bank_en_r;

  // input stage
  logic       s1_valid_r;
  opcode_t    s1_opcode_r;
  logic [3:0] s1_offset_r;
  logic [7:0] s1_wdata_r;
  logic [8:0] s1_key_r;
  logic       s1_other_r;

  // block state
  logic [3:0] cause_r, cause_nxt;
  logic [6:0] enable_r, enable_nxt;
  logic       beep_r, beep_nxt;
  logic       speaker_r, speaker_nxt;
  logic       rom_r, rom_nxt;
  logic       boot_r, boot_nxt;

  // output stage
  logic       out_valid_r;
  logic [7:0] rdata_r, rdata_nxt;
  logic       handled_r, handled_nxt;
  logic [3:0] pend_r, pend_nxt;

  logic s1_adv;
  logic bank_ok;
  logic [3:0] cause_cur;
  logic [7:0] key_hi;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign bank_ok   = !fm8_mode_r || bank_en_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fm8_mode_r  <= 1'b0;
      low_speed_r <= 1'b0;
      bank_en_r   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FM8_MODE:  fm8_mode_r  <= cfg_data;
        CFG_LOW_SPEED: low_speed_r <= cfg_data;
        CFG_BANK_EN:   bank_en_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_opcode_r <= opcode_t'(in_opcode);
      s1_offset_r <= in_reg_offset;
      s1_wdata_r  <= in_write_data;
      s1_key_r    <= in_key_code;
      s1_other_r  <= in_other_irq_pending;
    end
  end

  // causes as seen before the item
  assign cause_cur = {cause_r[C_DISK] | s1_other_r, cause_r[C_TIMER], cause_r[C_PRN],
                      cause_r[C_KEY] & enable_r[E_KEY]};

  // key high read value
  always_comb begin
    key_hi = (fm8_mode_r || s1_key_r[8]) ? RD_ALL_ONES : KEY_HI_CLEAR;
    if (low_speed_r) key_hi = key_hi & LOW_SPEED_MASK;
  end

  // item decode and next state
  always_comb begin
    cause_nxt   = cause_r;
    enable_nxt  = enable_r;
    beep_nxt    = beep_r;
    speaker_nxt = speaker_r;
    rom_nxt     = rom_r;
    boot_nxt    = boot_r;
    rdata_nxt   = 8'h00;
    handled_nxt = 1'b0;
    unique case (s1_opcode_r)
      OP_READ: begin
        unique case (s1_offset_r)
          OFF_KEY_HI: begin
            rdata_nxt   = key_hi;
            handled_nxt = 1'b1;
          end
          OFF_KEY_LO: begin
            if (!fm8_mode_r) begin
              rdata_nxt        = s1_key_r[7:0];
              handled_nxt      = 1'b1;
              cause_nxt[C_KEY] = 1'b0;
            end
          end
          OFF_CAUSE: begin
            if (!fm8_mode_r) begin
              rdata_nxt          = {4'hf, ~cause_cur};
              handled_nxt        = 1'b1;
              cause_nxt[C_PRN]   = 1'b0;
              cause_nxt[C_TIMER] = 1'b0;
            end
          end
          OFF_ROM_SW: begin
            if (bank_ok) begin
              rdata_nxt   = RD_ALL_ONES;
              handled_nxt = 1'b1;
              rom_nxt     = 1'b1;
              if (fm8_mode_r) boot_nxt = 1'b1;
            end
          end
          default: ;
        endcase
      end
      OP_WRITE: begin
        unique case (s1_offset_r)
          OFF_IRQ_EN: begin
            if (!fm8_mode_r) begin
              enable_nxt  = {s1_wdata_r[7:4], s1_wdata_r[2:0]};
              handled_nxt = 1'b1;
            end
          end
          OFF_CAUSE: begin
            speaker_nxt = s1_wdata_r[0];
            beep_nxt    = |s1_wdata_r[7:6];
            handled_nxt = 1'b1;
          end
          OFF_ROM_SW: begin
            if (bank_ok) begin
              handled_nxt = 1'b1;
              rom_nxt     = 1'b0;
              if (fm8_mode_r) boot_nxt = 1'b0;
            end
          end
          default: ;
        endcase
      end
      OP_TIMER: begin
        if (!fm8_mode_r) cause_nxt[C_TIMER] = enable_r[E_TIMER];
      end
      OP_BEEP_END: beep_nxt = 1'b0;
      OP_DISK_IRQ: begin
        if (!fm8_mode_r && enable_r[E_DISK]) cause_nxt[C_DISK] = 1'b1;
      end
      OP_PRN_IRQ: begin
        if (!fm8_mode_r && enable_r[E_PRN]) cause_nxt[C_PRN] = 1'b1;
      end
      OP_KEY_PRESS: begin
        if (!fm8_mode_r) cause_nxt[C_KEY] = 1'b1;
      end
      OP_DISK_ACK: cause_nxt[C_DISK] = 1'b0;
      default: ;
    endcase
    // causes after the item
    pend_nxt = {cause_nxt[C_DISK] | s1_other_r, cause_nxt[C_TIMER], cause_nxt[C_PRN],
                cause_nxt[C_KEY] & enable_nxt[E_KEY]};
  end

  // block state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cause_r   <= 4'h0;
      enable_r  <= 7'h00;
      beep_r    <= 1'b0;
      speaker_r <= 1'b0;
      rom_r     <= 1'b1;
      boot_r    <= 1'b1;
    end else if (s1_adv) begin
      cause_r   <= cause_nxt;
      enable_r  <= enable_nxt;
      beep_r    <= beep_nxt;
      speaker_r <= speaker_nxt;
      rom_r     <= rom_nxt;
      boot_r    <= boot_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rdata_r   <= rdata_nxt;
      handled_r <= handled_nxt;
      pend_r    <= pend_nxt;
    end
  end

  // state fields track the block state, which changes only as items leave s1
  assign out_valid          = out_valid_r;
  assign out_read_data      = rdata_r;
  assign out_handled        = handled_r;
  assign out_pending_causes = pend_r;
  assign out_beep_on        = beep_r;
  assign out_speaker_on     = speaker_r;
  assign out_basic_rom_on   = rom_r;
  assign out_basic_boot     = boot_r;

endmodule

/* rtl/mibc_checker.sv */
// ---------------------------------------------------------------------------
// mibc_checker
// Port-level checks of the controller, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mibc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data,
  input logic       out_handled,
  input logic [3:0] out_pending_causes,
  input logic       out_beep_on,
  input logic       out_basic_rom_on,
  input logic       out_basic_boot
);

  // reset empties the output stage
  `ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_valid, "output valid after reset")

  // a stalled item holds its fields
  `ASSERT_RST(a_stall_hold, clk, rst_n,
              out_valid && !out_ready |=> out_valid && $stable(out_read_data) &&
              $stable(out_handled) && $stable(out_pending_causes) &&
              $stable(out_beep_on) && $stable(out_basic_rom_on) &&
              $stable(out_basic_boot), "stalled result changed")

  // items not decoded return zero
  `ASSERT_RST(a_unhandled_zero, clk, rst_n, out_valid && !out_handled |-> out_read_data == 8'h00, "unhandled item returned data")

  // both stages full and stalled: no further input taken
  `ASSERT_RST(a_full_stall, clk, rst_n, out_valid && !out_ready && $past(out_valid && !out_ready) && $past(in_valid && in_ready) |-> !in_ready, "input taken with both stages full")

endmodule

bind main_io_interrupt_beep_controller_top mibc_checker u_mibc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_read_data      (out_read_data),
  .out_handled        (out_handled),
  .out_pending_causes (out_pending_causes),
  .out_beep_on        (out_beep_on),
  .out_basic_rom_on   (out_basic_rom_on),
  .out_basic_boot     (out_basic_boot)
);
